// File: rtl/tcfa_pkg.sv
// Package for the timecode frame arithmetic block: widths, opcodes, cell payload type.
// No dependencies.
`timescale 1ns / 1ps
package tcfa_pkg;
	localparam int MaxFrameRate = 120;
	localparam int NumCells = 21;
	localparam logic [2:0] OP_ADD_CNT = 3'd0;
	localparam logic [2:0] OP_SUB_CNT = 3'd1;
	localparam logic [2:0] OP_ADD_B   = 3'd2;
	localparam logic [2:0] OP_SUB_B   = 3'd3;
	localparam logic [2:0] OP_CNT     = 3'd4;

	// One item in flight through the divider chain.
	typedef struct packed {
		logic        vld;
		logic        neg;
		logic        drop;
		logic [31:0] total;
		logic [31:0] rem;    // magnitude being divided
		logic [20:0] quo;    // hours quotient bits
		logic [18:0] divh;   // rate*3600
		logic [12:0] divm;   // rate*60
		logic [6:0]  divs;   // rate
	} cell_t;
endpackage

// File: rtl/timecode_frame_arithmetic.sv
// Top level of the timecode frame arithmetic block: conversion, chain of divider cells, output split.
// Depends on tcfa_pkg and tcfa_cell.
`timescale 1ns / 1ps
//  channel | handshake            | beat
//  in      | in_valid / in_ready   | opcode, A, B, count
//  out     | out_valid / out_ready | total, hours..frames, drop
//  cfg     | APB psel/penable      | frame_rate at address 0
// One beat enters per cycle while the pipe is not stalled. The pipe is made of
// two conversion stages, 21 divider cells (one hours quotient bit each), minutes
// and seconds stages and the output register. The whole pipe advances together
// and stalls when the output register holds a beat that is not taken. Reset
// clears all valid bits and sets frame_rate to 30. Minutes, seconds and frames
// are found with small dividers since their values stay below 60 and 120.
module timecode_frame_arithmetic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [6:0]  a_hours,
	input  logic [5:0]  a_minutes,
	input  logic [5:0]  a_seconds,
	input  logic [6:0]  a_frames,
	input  logic        a_drop,
	input  logic [6:0]  b_hours,
	input  logic [5:0]  b_minutes,
	input  logic [5:0]  b_seconds,
	input  logic [6:0]  b_frames,
	input  logic signed [31:0] count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] total,
	output logic signed [20:0] hours,
	output logic signed [6:0]  minutes,
	output logic signed [6:0]  seconds,
	output logic signed [7:0]  frames,
	output logic        drop,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tcfa_pkg::*;

	logic [6:0] frame_rate_q;
	logic [6:0] rate;
	logic adv;
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {25'd0, frame_rate_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= 7'd30;
		end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
			frame_rate_q <= pwdata[6:0];
		end
	end
	always_comb begin
		rate = frame_rate_q;
		if (rate == 7'd0) rate = 7'd1;
		if (rate > 7'(MaxFrameRate)) rate = 7'(MaxFrameRate);
	end

	// The whole pipe moves when the output register is free or being emptied.
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: partial products of the conversions.
	logic vld_s1, drop_s1;
	logic [2:0] op_s1;
	logic [31:0] cnt_s1, pa_s1, pb_s1, qa_s1, qb_s1;
	logic [18:0] divh_s1;
	logic [12:0] divm_s1;
	logic [6:0] divs_s1;
	logic [18:0] rh;
	logic [12:0] rm;
	assign rh = 19'(rate) * 19'd3600;
	assign rm = 13'(rate) * 13'd60;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= opcode; drop_s1 <= a_drop; cnt_s1 <= count;
			divh_s1 <= rh; divm_s1 <= rm; divs_s1 <= rate;
			pa_s1 <= 32'(a_hours) * 32'(rh) + 32'(a_minutes) * 32'(rm);
			qa_s1 <= 32'(a_seconds) * 32'(rate) + 32'(a_frames);
			pb_s1 <= 32'(b_hours) * 32'(rh) + 32'(b_minutes) * 32'(rm);
			qb_s1 <= 32'(b_seconds) * 32'(rate) + 32'(b_frames);
		end
	end

	// Stage 2: totals, opcode select, sign and magnitude.
	logic [31:0] ta, tb, tot;
	always_comb begin
		ta = pa_s1 + qa_s1;
		tb = pb_s1 + qb_s1;
		case (op_s1)
			OP_ADD_CNT: tot = ta + cnt_s1;
			OP_SUB_CNT: tot = ta - cnt_s1;
			OP_ADD_B:   tot = ta + tb;
			OP_SUB_B:   tot = ta - tb;
			OP_CNT:     tot = cnt_s1;
			default:    tot = ta;
		endcase
	end
	logic vld_s2, neg_s2, drop_s2;
	logic [31:0] tot_s2, rem_s2;
	logic [18:0] divh_s2;
	logic [12:0] divm_s2;
	logic [6:0] divs_s2;
	cell_t chain [NumCells:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= tot[31];
			drop_s2 <= drop_s1;
			tot_s2 <= tot;
			rem_s2 <= tot[31] ? (32'd0 - tot) : tot;
			divh_s2 <= divh_s1;
			divm_s2 <= divm_s1;
			divs_s2 <= divs_s1;
		end
	end
	// The head of the chain starts with an empty quotient.
	assign chain[0] = {vld_s2, neg_s2, drop_s2, tot_s2, rem_s2, 21'd0,
		divh_s2, divm_s2, divs_s2};

	// Chain of cells, most significant quotient bit first.
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		tcfa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .bit_idx(5'(NumCells - 1 - i)),
			.d(chain[i]), .q(chain[i+1])
		);
	end

	// Minutes stage: remainder below rate*3600, quotient below 64.
	cell_t last;
	logic [5:0] mq;
	logic [31:0] mr;
	assign last = chain[NumCells];
	always_comb begin
		mq = 6'd0;
		mr = last.rem;
		for (int k = 5; k >= 0; k--) begin
			if (mr >= (32'(last.divm) << k)) begin
				mr = mr - (32'(last.divm) << k);
				mq[k] = 1'b1;
			end
		end
	end
	logic vld_s3, neg_s3, drop_s3;
	logic [31:0] tot_s3;
	logic [20:0] h_s3;
	logic [5:0] m_s3;
	logic [12:0] r_s3;
	logic [6:0] ds_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= last.vld;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= last.neg; drop_s3 <= last.drop; tot_s3 <= last.total;
			h_s3 <= last.quo; m_s3 <= mq; r_s3 <= mr[12:0]; ds_s3 <= last.divs;
		end
	end

	// Seconds stage.
	logic [5:0] sq;
	logic [12:0] sr;
	always_comb begin
		sq = 6'd0;
		sr = r_s3;
		for (int k = 5; k >= 0; k--) begin
			if (sr >= (13'(ds_s3) << k)) begin
				sr = sr - (13'(ds_s3) << k);
				sq[k] = 1'b1;
			end
		end
	end
	logic vld_s4, neg_s4, drop_s4;
	logic [31:0] tot_s4;
	logic [20:0] h_s4;
	logic [5:0] m_s4, s_s4;
	logic [6:0] f_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s4 <= neg_s3; drop_s4 <= drop_s3; tot_s4 <= tot_s3;
			h_s4 <= h_s3; m_s4 <= m_s3; s_s4 <= sq; f_s4 <= sr[6:0];
		end
	end

	// Output register: apply the total's sign to the hours, minutes, seconds and frames fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			total <= tot_s4;
			drop <= drop_s4;
			hours <= neg_s4 ? -$signed(h_s4) : $signed(h_s4);
			minutes <= neg_s4 ? -$signed({1'b0, m_s4}) : $signed({1'b0, m_s4});
			seconds <= neg_s4 ? -$signed({1'b0, s_s4}) : $signed({1'b0, s_s4});
			frames <= neg_s4 ? -$signed({1'b0, f_s4}) : $signed({1'b0, f_s4});
		end
	end
endmodule

// File: rtl/tcfa_cell.sv
// One restoring division step of the hours divider chain.
// Depends on tcfa_pkg.
`timescale 1ns / 1ps
module tcfa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [4:0]      bit_idx,
	input  tcfa_pkg::cell_t d,
	output tcfa_pkg::cell_t q
);
	import tcfa_pkg::*;
	logic [63:0] shifted;
	cell_t nx;
	logic vld_q;
	logic [$bits(cell_t)-2:0] dat_q;
	always_comb begin
		nx = d;
		shifted = {45'd0, d.divh} << bit_idx;
		if ({32'd0, d.rem} >= shifted) begin
			nx.rem = d.rem - shifted[31:0];
			nx.quo = d.quo | (21'd1 << bit_idx);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nx[$bits(cell_t)-2:0];
		end
	end
	assign q = {vld_q, dat_q};
endmodule

// File: test/timecode_frame_arithmetic_tb.sv
// Testbench for the timecode frame arithmetic block: directed table, then random beats
// under several idling phases, each result checked against a typed-in value or a local frame calculator.
// Depends on tcfa_pkg and the timecode_frame_arithmetic RTL.
`timescale 1ns / 1ps
module timecode_frame_arithmetic_tb;
	import tcfa_pkg::*;

	localparam logic CFG_FRAME_RATE = 1'b0;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [2:0]  op;
		logic [6:0]  ah;
		logic [5:0]  am;
		logic [5:0]  as_;
		logic [6:0]  af;
		logic        ad;
		logic [6:0]  bh;
		logic [5:0]  bm;
		logic [5:0]  bs;
		logic [6:0]  bf;
		logic [31:0] cnt;
	} tc_req_t;

	typedef struct packed {
		logic [31:0] total;
		logic [20:0] hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [7:0]  frames;
		logic        drop;
	} tc_res_t;

	typedef struct {
		tc_req_t req;
		logic    known;
		tc_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [6:0] a_hours = '0;
	logic [5:0] a_minutes = '0;
	logic [5:0] a_seconds = '0;
	logic [6:0] a_frames = '0;
	logic a_drop = 1'b0;
	logic [6:0] b_hours = '0;
	logic [5:0] b_minutes = '0;
	logic [5:0] b_seconds = '0;
	logic [6:0] b_frames = '0;
	logic signed [31:0] count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] total;
	logic signed [20:0] hours;
	logic signed [6:0] minutes;
	logic signed [6:0] seconds;
	logic signed [7:0] frames;
	logic drop;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic paddr = 1'b0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	timecode_frame_arithmetic dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copy of the rate register, as written.
	logic [6:0] rate_reg = 7'd30;
	tc_res_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic tc_res_t compute_timecode(tc_req_t r, logic [6:0] rate_field);
		logic [31:0] rate;
		logic [31:0] ta;
		logic [31:0] tb;
		logic [31:0] tot;
		longint v;
		longint ph;
		longint pm;
		longint ps;
		tc_res_t o;
		rate = rate_field;
		// A zero rate counts as one, anything above the maximum is clamped.
		if (rate == 0) rate = 1;
		if (rate > MaxFrameRate) rate = MaxFrameRate;
		ta = r.ah * rate * 32'd3600 + r.am * rate * 32'd60 + r.as_ * rate + r.af;
		tb = r.bh * rate * 32'd3600 + r.bm * rate * 32'd60 + r.bs * rate + r.bf;
		case (r.op)
			OP_ADD_CNT: tot = ta + r.cnt;
			OP_SUB_CNT: tot = ta - r.cnt;
			OP_ADD_B:   tot = ta + tb;
			OP_SUB_B:   tot = ta - tb;
			OP_CNT:     tot = r.cnt;
			default:    tot = ta;
		endcase
		v = longint'($signed(tot));
		ph = longint'(rate) * 3600;
		pm = longint'(rate) * 60;
		ps = longint'(rate);
		o.total = tot;
		o.hours = 21'(v / ph);
		v = v % ph;
		o.minutes = 7'(v / pm);
		v = v % pm;
		o.seconds = 7'(v / ps);
		o.frames = 8'(v % ps);
		o.drop = r.ad;
		return o;
	endfunction

	task automatic write_rate(logic [6:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_FRAME_RATE;
		pwdata <= {25'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rate_reg = val;
	endtask

	// Send one beat; holds valid until accepted. Idle gaps precede the beat.
	task automatic send_beat(tc_req_t r, logic known, tc_res_t want);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{opcode, a_hours, a_minutes, a_seconds, a_frames, a_drop,
			b_hours, b_minutes, b_seconds, b_frames, count} <= r;
		// Ready is settled at the falling edge and holds until the next rising edge.
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		// Accepted at this edge.
		pending_results.push_back(known ? want : compute_timecode(r, rate_reg));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, compare each taken beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no expectation, total %0d", $time, total);
					errors++;
				end else begin
					tc_res_t e;
					e = pending_results.pop_front();
					if (e.total !== total) begin
						$display("%0t: total exp %0d got %0d", $time, $signed(e.total), total);
						errors++;
					end
					if (e.hours !== hours) begin
						$display("%0t: hours exp %0d got %0d", $time, $signed(e.hours), hours);
						errors++;
					end
					if (e.minutes !== minutes) begin
						$display("%0t: minutes exp %0d got %0d", $time,
							$signed(e.minutes), minutes);
						errors++;
					end
					if (e.seconds !== seconds) begin
						$display("%0t: seconds exp %0d got %0d", $time,
							$signed(e.seconds), seconds);
						errors++;
					end
					if (e.frames !== frames) begin
						$display("%0t: frames exp %0d got %0d", $time,
							$signed(e.frames), frames);
						errors++;
					end
					if (e.drop !== drop) begin
						$display("%0t: drop exp %0b got %0b", $time, e.drop, drop);
						errors++;
					end
				end
			end
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic tc_req_t random_request();
		tc_req_t r;
		r = tc_req_t'($bits(tc_req_t)'({$urandom, $urandom, $urandom}));
		// Mostly in-range timecodes; sometimes raw bits to cover out-of-range fields.
		if ($urandom_range(9) != 0) begin
			r.op = $urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4));
			r.ah = 7'($urandom_range(99));
			r.am = 6'($urandom_range(59));
			r.as_ = 6'($urandom_range(59));
			r.af = 7'($urandom_range(119));
			r.bh = 7'($urandom_range(99));
			r.bm = 6'($urandom_range(59));
			r.bs = 6'($urandom_range(59));
			r.bf = 7'($urandom_range(119));
			case ($urandom_range(3))
				0: r.cnt = $urandom_range(200000);
				1: r.cnt = -$urandom_range(200000);
				default: r.cnt = $urandom;
			endcase
		end
		return r;
	endfunction

	dir_row_t dir_table[$];

	function automatic tc_req_t mk(logic [2:0] op, logic [6:0] ah, logic [5:0] am,
			logic [5:0] as_, logic [6:0] af, logic ad, logic [6:0] bh, logic [5:0] bm,
			logic [5:0] bs, logic [6:0] bf, logic [31:0] cnt);
		return {op, ah, am, as_, af, ad, bh, bm, bs, bf, cnt};
	endfunction

	task automatic add_row(tc_req_t r, logic known, tc_res_t res);
		dir_row_t d;
		d.req = r;
		d.known = known;
		d.res = res;
		dir_table.push_back(d);
	endtask

	task automatic run_random(int n);
		repeat (n) send_beat(random_request(), 1'b0, '0);
	endtask

	initial begin
		#(12 * 600000);
		$display("Verification failed");
		$finish;
	end

	initial begin
		// Rows with results typed in hold at the reset rate of 30.
		add_row(mk(OP_ADD_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 0});
		add_row(mk(OP_CNT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 108000), 1, '{108000, 1, 0, 0, 0, 1});
		add_row(mk(OP_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1), 1, '{-1, 0, 0, 0, -1, 0});
		add_row(mk(OP_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000), 0, '0);
		add_row(mk(OP_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 0, '0);
		add_row(mk(OP_ADD_CNT, 99, 59, 59, 119, 1, 0, 0, 0, 0, 1), 0, '0);
		add_row(mk(OP_SUB_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, '{-1, 0, 0, 0, -1, 0});
		add_row(mk(OP_SUB_CNT, 1, 2, 3, 4, 0, 0, 0, 0, 0, 32'h8000_0000), 0, '0);
		add_row(mk(OP_ADD_B, 99, 59, 59, 29, 0, 99, 59, 59, 29, 0), 0, '0);
		add_row(mk(OP_SUB_B, 0, 0, 0, 0, 1, 99, 59, 59, 119, 0), 0, '0);
		add_row(mk(OP_SUB_B, 5, 0, 0, 0, 0, 5, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 0});
		add_row(mk(3'd5, 0, 0, 1, 0, 0, 0, 0, 0, 0, 77), 1, '{30, 0, 0, 1, 0, 0});
		add_row(mk(3'd6, 1, 0, 0, 0, 1, 9, 9, 9, 9, 5), 0, '0);
		add_row(mk(3'd7, 0, 1, 0, 0, 0, 0, 0, 0, 0, 5), 0, '0);
		add_row(mk(OP_ADD_CNT, 127, 63, 63, 127, 1, 127, 63, 63, 127, 32'hFFFF_FFFF), 0, '0);
		add_row(mk(OP_ADD_B, 127, 63, 63, 127, 0, 127, 63, 63, 127, 0), 0, '0);
		add_row(mk(OP_SUB_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h5555_5555), 0, '0);
		add_row(mk(OP_ADD_CNT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 32'hAAAA_AAAA), 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;
		@(posedge clk);

		// Directed part at the reset rate, no idling.
		foreach (dir_table[i]) send_beat(dir_table[i].req, dir_table[i].known,
			dir_table[i].res);
		wait_drained();

		// Zero rate acts as one, and rates above the maximum clamp.
		write_rate(7'd0);
		send_beat(mk(OP_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3661), 1'b0, '0);
		run_random(40);
		wait_drained();
		write_rate(7'd127);
		run_random(40);
		wait_drained();
		write_rate(7'd120);
		run_random(40);
		wait_drained();
		write_rate(7'd1);
		run_random(40);
		wait_drained();

		// Random phases over several rates and idling patterns.
		for (int ph = 0; ph < 4; ph++) begin
			write_rate(ph == 0 ? 7'd25 : 7'($urandom_range(127)));
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 13 : 75) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 13 : 75) : 0;
			run_random(130);
			// Hold off until the pipe is empty, then continue the phase.
			in_valid <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
			run_random(130);
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_rate(7'd30);
		run_random(60);
		wait_drained();

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
